// ===== sv/bbs_pkg.sv =====
// Shared widths, register indexes and reset values of the Blum Blum Shub bit generator.
`default_nettype none

package bbs_pkg;

    localparam int unsigned PRIME_W   = 16;
    localparam int unsigned SEED_W    = 32;
    localparam int unsigned STATE_W   = 32;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 32;
    localparam int unsigned MOD_BITS  = 32;

    localparam logic [CFG_IDX_W-1:0] REG_PRIME_P = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRIME_Q = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEED    = 2'd2;

    localparam logic [PRIME_W-1:0] PRIME_P_RESET = 16'd3;
    localparam logic [PRIME_W-1:0] PRIME_Q_RESET = 16'd7;
    localparam logic [SEED_W-1:0]  SEED_RESET    = 32'd2;

endpackage

`default_nettype wire

// ===== sv/bbs_if.sv =====
// Request and result channels of the Blum Blum Shub bit generator.
`default_nettype none

interface bbs_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface bbs_bit_if;
    logic                        valid;
    logic                        ready;
    logic                        random_bit;
    logic [bbs_pkg::STATE_W-1:0] state_value;

    modport source (output valid, output random_bit, output state_value, input ready);
    modport sink   (input valid, input random_bit, input state_value, output ready);
endinterface

`default_nettype wire

// ===== sv/bbs_random_bit_generator.sv =====
// Blum Blum Shub bit generator with a bit-serial modular squaring datapath.
//
// Usage: write prime_p, prime_q and seed through the plain write port while the
// block is idle (index 0, 1, 2; other indexes are dropped). Each transfer on
// i_req asks for one bit; the result transfer on o_bit carries the new state
// and its least significant bit. The modulus is prime_p * prime_q cut to
// MOD_BITS bits and is sampled at the start of every request.
// Steps: sample the modulus, reduce the 32-bit operand mod n (one bit a
// cycle), square mod n (one multiplier bit a cycle), hand over the result.
// The first request after reset or one with restart set squares twice.
// The result register parts the channels: a new request is taken while the
// previous result still waits, and a finished result waits in the handover
// state while the receiver stalls; no request is taken until it is placed.
// Reset (synchronous, active low) restores the register reset values, clears
// the state to zero and marks the generator as not yet seeded.
`default_nettype none

module bbs_random_bit_generator #(
    parameter int unsigned MOD_BITS = bbs_pkg::MOD_BITS
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    bbs_req_if.sink                        i_req,
    bbs_bit_if.source                      o_bit,
    input  wire                            i_cfg_we,
    input  wire [bbs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [bbs_pkg::CFG_DAT_W-1:0]   i_cfg_data
);

    localparam int unsigned NW     = MOD_BITS;
    localparam int unsigned XW     = bbs_pkg::STATE_W;
    localparam int unsigned PW     = 2 * bbs_pkg::PRIME_W;
    localparam int unsigned CMAX   = (XW > NW) ? XW : NW;
    localparam int unsigned CW     = $clog2(CMAX);
    localparam logic [CW-1:0] RED_LAST = CW'(XW - 1);
    localparam logic [CW-1:0] SQR_LAST = CW'(NW - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_RED,
        S_SQR,
        S_DONE
    } t_state;

    // configuration
    logic [bbs_pkg::PRIME_W-1:0] r_prime_p;
    logic [bbs_pkg::PRIME_W-1:0] r_prime_q;
    logic [bbs_pkg::SEED_W-1:0]  r_seed;

    // control
    t_state          r_state;
    logic            r_loaded;
    logic            r_two;
    logic            r_zero;
    logic [CW-1:0]   r_cnt;

    // datapath
    logic [NW-1:0]   r_n;
    logic [XW-1:0]   r_x;
    logic [NW-1:0]   r_rem;
    logic [NW-1:0]   r_y;
    logic [NW-1:0]   r_xd;
    logic [NW-1:0]   r_acc;
    logic [XW-1:0]   r_cv;

    // result register
    logic            r_out_valid;
    logic            r_out_bit;
    logic [XW-1:0]   r_out_state;

    logic [PW-1:0]   n_prod;
    logic [NW-1:0]   n_rem;
    logic [NW-1:0]   n_acc;
    logic [NW-1:0]   n_xd;
    logic            n_seed_path;

    // (a + b) mod n for a, b below n
    function automatic logic [NW-1:0] add_mod(
        input logic [NW-1:0] a,
        input logic [NW-1:0] b,
        input logic [NW-1:0] n
    );
        logic [NW:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= {1'b0, n}) begin
            sum = sum - {1'b0, n};
        end
        return sum[NW-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prime_p <= bbs_pkg::PRIME_P_RESET;
            r_prime_q <= bbs_pkg::PRIME_Q_RESET;
            r_seed    <= bbs_pkg::SEED_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bbs_pkg::REG_PRIME_P: r_prime_p <= i_cfg_data[bbs_pkg::PRIME_W-1:0];
                bbs_pkg::REG_PRIME_Q: r_prime_q <= i_cfg_data[bbs_pkg::PRIME_W-1:0];
                bbs_pkg::REG_SEED:    r_seed    <= i_cfg_data[bbs_pkg::SEED_W-1:0];
                default: ;
            endcase
        end
    end

    assign n_prod      = PW'(r_prime_p) * PW'(r_prime_q);
    assign n_seed_path = i_req.restart | ~r_loaded;

    // one restoring step of the reduction: shift in the next operand bit
    always_comb begin
        logic [NW:0] t;
        t = {r_rem, r_x[XW-1]};
        if (t >= {1'b0, r_n}) begin
            t = t - {1'b0, r_n};
        end
        n_rem = t[NW-1:0];
    end

    // one step of the LSB-first squaring: add the doubled operand, double it again
    assign n_acc = r_y[0] ? add_mod(r_acc, r_xd, r_n) : r_acc;
    assign n_xd  = add_mod(r_xd, r_xd, r_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_loaded    <= 1'b0;
            r_two       <= 1'b0;
            r_zero      <= 1'b0;
            r_cnt       <= '0;
            r_cv        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the result once the receiver has taken it
            if (r_out_valid && o_bit.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_two   <= n_seed_path;
                        r_x     <= n_seed_path ? r_seed : r_cv;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_n     <= NW'(n_prod);
                    r_zero  <= (NW'(n_prod) <= NW'(1));
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_RED;
                end
                S_RED: begin
                    r_rem <= n_rem;
                    r_x   <= {r_x[XW-2:0], 1'b0};
                    if (r_cnt == RED_LAST) begin
                        r_y     <= n_rem;
                        r_xd    <= n_rem;
                        r_acc   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_SQR;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_SQR: begin
                    if (r_cnt != SQR_LAST) begin
                        r_acc <= n_acc;
                        r_xd  <= n_xd;
                        r_y   <= {1'b0, r_y[NW-1:1]};
                        r_cnt <= r_cnt + CW'(1);
                    end else if (r_two) begin
                        // seed squared is already below n: square it again
                        r_cnt <= '0;
                        r_two <= 1'b0;
                        r_y   <= n_acc;
                        r_xd  <= n_acc;
                        r_acc <= '0;
                    end else begin
                        r_cnt    <= '0;
                        r_cv     <= r_zero ? '0 : XW'(n_acc);
                        r_loaded <= 1'b1;
                        r_state  <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hold until the result register is free
                    if (!r_out_valid || o_bit.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_bit   <= r_cv[0];
                        r_out_state <= r_cv;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_bit.valid       = r_out_valid;
    assign o_bit.random_bit  = r_out_bit;
    assign o_bit.state_value = r_out_state;

    // a fresh result only ever comes from the handover state
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_bit.valid) |-> $past(r_state == S_DONE))
        else $error("result appeared outside the handover state");

    // the bit is the low bit of the state it is sent with
    a_bit_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_bit.valid |-> (o_bit.random_bit == o_bit.state_value[0]))
        else $error("random bit differs from state lsb");

    // partial products stay reduced below a usable modulus
    a_acc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQR && !r_zero) |-> (r_acc < r_n && r_xd < r_n))
        else $error("squaring operand escaped the modulus");

    // an accepted request always starts by sampling the modulus
    a_accept_to_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state == S_PREP))
        else $error("accepted request did not start");

endmodule

`default_nettype wire
